// File: rtl/core/pidfd_pkg.sv
// Shared constants, types and saturating helpers for the PID controller core.
// No dependencies; imported by pid_filtered_derivative_clamped.
package pidfd_pkg;

  localparam int DATA_WIDTH      = 32;
  localparam int FRAC_BITS       = 16;
  localparam int GAIN_WIDTH      = DATA_WIDTH - 1;
  localparam int DIGIT_WIDTH     = 8;
  localparam int DIGIT_COUNT     = DATA_WIDTH / DIGIT_WIDTH;
  localparam int DIGIT_CNT_WIDTH = $clog2(DIGIT_COUNT);
  localparam int PROD_WIDTH      = 2 * DATA_WIDTH;
  localparam int WIDE_WIDTH      = DATA_WIDTH + 2;
  localparam int CFG_INDEX_WIDTH = 3;

  typedef logic signed [DATA_WIDTH-1:0] word_t;
  typedef logic signed [WIDE_WIDTH-1:0] wide_t;
  typedef logic signed [PROD_WIDTH-1:0] prod_t;
  typedef logic [GAIN_WIDTH-1:0]        gain_t;

  // Fixed-point scale factors (T = tau = 0.02)
  localparam longint ONE_Q    = longint'(1) << FRAC_BITS;
  localparam longint ISCALE_Q = (ONE_Q + 50) / 100;       // 0.5*T
  localparam longint DSCALE_Q = (ONE_Q * 100 + 1) / 3;    // 2/(2*tau+T)
  localparam longint DECAY_Q  = (ONE_Q + 1) / 3;          // (2*tau-T)/(2*tau+T)
  localparam logic [DATA_WIDTH-1:0] ISCALE = DATA_WIDTH'(ISCALE_Q);
  localparam logic [DATA_WIDTH-1:0] DSCALE = DATA_WIDTH'(DSCALE_Q);
  localparam logic [DATA_WIDTH-1:0] DECAY  = DATA_WIDTH'(DECAY_Q);

  // Register map
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_GAIN_P      = 3'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_GAIN_I      = 3'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_GAIN_D      = 3'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_DEADBAND    = 3'd3;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_DRIVE_UPPER = 3'd4;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_DRIVE_LOWER = 3'd5;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_ACCUM_UPPER = 3'd6;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_ACCUM_LOWER = 3'd7;

  localparam gain_t DEADBAND_RST    = GAIN_WIDTH'(66);
  localparam word_t DRIVE_UPPER_RST = DATA_WIDTH'(45875);
  localparam word_t DRIVE_LOWER_RST = -DATA_WIDTH'(45875);
  localparam word_t ACCUM_UPPER_RST = DATA_WIDTH'(32768);
  localparam word_t ACCUM_LOWER_RST = -DATA_WIDTH'(32768);

  localparam word_t WORD_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam word_t WORD_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  function automatic wide_t ext(input word_t a);
    return {{2{a[DATA_WIDTH-1]}}, a};
  endfunction

  // Saturate a widened sum back to the data range
  function automatic word_t sat_wide(input wide_t v);
    logic [2:0] top;
    top = v[WIDE_WIDTH-1:DATA_WIDTH-1];
    if ((&top) || !(|top)) return v[DATA_WIDTH-1:0];
    else if (v[WIDE_WIDTH-1]) return WORD_MIN;
    else return WORD_MAX;
  endfunction

  // Floor-shift a full product by FRAC_BITS and saturate
  function automatic word_t qround(input prod_t p);
    logic [PROD_WIDTH-FRAC_BITS-DATA_WIDTH:0] top;
    top = p[PROD_WIDTH-1:FRAC_BITS+DATA_WIDTH-1];
    if ((&top) || !(|top)) return p[FRAC_BITS+DATA_WIDTH-1:FRAC_BITS];
    else if (p[PROD_WIDTH-1]) return WORD_MIN;
    else return WORD_MAX;
  endfunction

  // Upper limit wins when the limits are inverted
  function automatic word_t clamp(input word_t v, input word_t hi, input word_t lo);
    if (v > hi) return hi;
    else if (v < lo) return lo;
    else return v;
  endfunction

endpackage

// File: rtl/core/pid_filtered_derivative_clamped.sv
// PID controller step: Q16.16 PID with trapezoidal integral and filtered derivative.
// Depends on pidfd_pkg (constants, saturation and rounding helpers).
//
// Channel  Dir  Handshake          Payload
// s_*      in   s_tvalid/s_tready  s_tdata: target[31:0], measured[63:32]
// m_*      out  m_tvalid/m_tready  m_tdata: drive[31:0]; m_tuser: at_target
// cfg_*    in   cfg_we             cfg_index selects register, cfg_data value
//
// An item passes one error/deadband check, six products on a
// shared 32x8 digit-serial multiplier (each: load, 4 digits, round),
// one state update and one output load; inside the deadband only check and load run.
// Reset is synchronous: controller state clears, registers take defaults.
// Next input is taken as soon as the sequencer is back in idle; a result not
// yet taken waits in the output register and only holds the final load.
module pid_filtered_derivative_clamped
  import pidfd_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [2*DATA_WIDTH-1:0]    s_tdata,   // target, measured
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [DATA_WIDTH-1:0]      m_tdata,   // drive
  output logic                       m_tuser,   // at_target
  input  logic                       cfg_we,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [DATA_WIDTH-1:0]      cfg_data
);

  // Sequencer states
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_CHECK  = 3'd1;
  localparam logic [2:0] ST_LOAD   = 3'd2;
  localparam logic [2:0] ST_MUL    = 3'd3;
  localparam logic [2:0] ST_STORE  = 3'd4;
  localparam logic [2:0] ST_UPDATE = 3'd5;
  localparam logic [2:0] ST_OUT    = 3'd6;

  // Product schedule
  localparam logic [2:0] OP_PROP  = 3'd0;  // gain_p * error
  localparam logic [2:0] OP_ISUM  = 3'd1;  // (error + last_error) * ISCALE
  localparam logic [2:0] OP_INC   = 3'd2;  // gain_i * scaled sum
  localparam logic [2:0] OP_DSUM  = 3'd3;  // (measured - last_measured) * DSCALE
  localparam logic [2:0] OP_DTERM = 3'd4;  // gain_d * scaled slope
  localparam logic [2:0] OP_DECAY = 3'd5;  // deriv * DECAY

  localparam logic [DIGIT_CNT_WIDTH-1:0] DIGIT_LAST = DIGIT_CNT_WIDTH'(DIGIT_COUNT - 1);

  // Configuration
  gain_t gain_p, gain_i, gain_d, deadband;
  word_t drive_upper, drive_lower, accum_upper, accum_lower;

  // Controller state
  word_t accum, last_error, deriv, last_measured;

  // Per-item working registers
  logic [2:0] state;
  logic [2:0] op;
  word_t      target, measured, err;
  logic       at_hit;
  word_t      prop, tmp, inc, dterm, decay;

  // Digit-serial multiplier
  word_t                          mul_a;
  logic [DATA_WIDTH-1:0]          mul_b;    // shifts out MSB digit first
  prod_t                          mul_acc;
  logic [DIGIT_CNT_WIDTH-1:0]     digit_cnt;
  logic [DIGIT_WIDTH-1:0]         digit;
  logic signed [DATA_WIDTH+DIGIT_WIDTH:0] partial;
  prod_t                          mul_acc_next;
  word_t                          mul_res;

  word_t                 err_next;
  logic [DATA_WIDTH-1:0] err_mag;
  word_t                 load_a;
  logic [DATA_WIDTH-1:0] load_b;
  word_t                 total;

  assign s_tready = (state == ST_IDLE);

  assign digit        = mul_b[DATA_WIDTH-1 -: DIGIT_WIDTH];
  assign partial      = mul_a * $signed({1'b0, digit});
  assign mul_acc_next = (mul_acc <<< DIGIT_WIDTH) + PROD_WIDTH'(partial);
  assign mul_res      = qround(mul_acc);

  // Error and magnitude; the most negative error maps to 2^31, beyond any deadband
  assign err_next = sat_wide(ext(target) - ext(measured));
  assign err_mag  = err_next[DATA_WIDTH-1] ? DATA_WIDTH'(-err_next) : DATA_WIDTH'(err_next);

  always_comb begin
    case (op)
      OP_PROP: begin
        load_a = err;
        load_b = {1'b0, gain_p};
      end
      OP_ISUM: begin
        load_a = sat_wide(ext(err) + ext(last_error));
        load_b = ISCALE;
      end
      OP_INC: begin
        load_a = tmp;
        load_b = {1'b0, gain_i};
      end
      OP_DSUM: begin
        load_a = sat_wide(ext(measured) - ext(last_measured));
        load_b = DSCALE;
      end
      OP_DTERM: begin
        load_a = tmp;
        load_b = {1'b0, gain_d};
      end
      OP_DECAY: begin
        load_a = deriv;
        load_b = DECAY;
      end
      default: begin
        load_a = '0;
        load_b = '0;
      end
    endcase
  end

  assign total = at_hit ? '0
               : clamp(sat_wide(ext(prop) + ext(accum) + ext(deriv)), drive_upper, drive_lower);

  // Register file writes
  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p      <= '0;
      gain_i      <= '0;
      gain_d      <= '0;
      deadband    <= DEADBAND_RST;
      drive_upper <= DRIVE_UPPER_RST;
      drive_lower <= DRIVE_LOWER_RST;
      accum_upper <= ACCUM_UPPER_RST;
      accum_lower <= ACCUM_LOWER_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GAIN_P:      gain_p      <= cfg_data[GAIN_WIDTH-1:0];
        REG_GAIN_I:      gain_i      <= cfg_data[GAIN_WIDTH-1:0];
        REG_GAIN_D:      gain_d      <= cfg_data[GAIN_WIDTH-1:0];
        REG_DEADBAND:    deadband    <= cfg_data[GAIN_WIDTH-1:0];
        REG_DRIVE_UPPER: drive_upper <= cfg_data;
        REG_DRIVE_LOWER: drive_lower <= cfg_data;
        REG_ACCUM_UPPER: accum_upper <= cfg_data;
        REG_ACCUM_LOWER: accum_lower <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer, controller state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      op            <= OP_PROP;
      digit_cnt     <= '0;
      m_tvalid      <= 1'b0;
      accum         <= '0;
      last_error    <= '0;
      deriv         <= '0;
      last_measured <= '0;
    end else begin
      // ST_OUT reloads the output register itself
      if (m_tvalid && m_tready && state != ST_OUT) m_tvalid <= 1'b0;

      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            target   <= s_tdata[DATA_WIDTH-1:0];
            measured <= s_tdata[2*DATA_WIDTH-1:DATA_WIDTH];
            state    <= ST_CHECK;
          end
        end

        ST_CHECK: begin
          err    <= err_next;
          at_hit <= (err_mag <= {1'b0, deadband});
          op     <= OP_PROP;
          state  <= (err_mag <= {1'b0, deadband}) ? ST_OUT : ST_LOAD;
        end

        ST_LOAD: begin
          mul_a     <= load_a;
          mul_b     <= load_b;
          mul_acc   <= '0;
          digit_cnt <= '0;
          state     <= ST_MUL;
        end

        ST_MUL: begin
          mul_acc   <= mul_acc_next;
          mul_b     <= mul_b << DIGIT_WIDTH;
          digit_cnt <= digit_cnt + 1'b1;
          if (digit_cnt == DIGIT_LAST) state <= ST_STORE;
        end

        ST_STORE: begin
          case (op)
            OP_PROP:  prop  <= mul_res;
            OP_ISUM:  tmp   <= mul_res;
            OP_INC:   inc   <= mul_res;
            OP_DSUM:  tmp   <= mul_res;
            OP_DTERM: dterm <= mul_res;
            OP_DECAY: decay <= mul_res;
            default: ;
          endcase
          if (op == OP_DECAY) begin
            state <= ST_UPDATE;
          end else begin
            op    <= op + 1'b1;
            state <= ST_LOAD;
          end
        end

        // Commit integrator, filtered derivative and history
        ST_UPDATE: begin
          accum         <= clamp(sat_wide(ext(accum) + ext(inc)), accum_upper, accum_lower);
          deriv         <= sat_wide(-(ext(dterm) + ext(decay)));
          last_error    <= err;
          last_measured <= measured;
          state         <= ST_OUT;
        end

        ST_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tdata  <= total;
            m_tuser  <= at_hit;
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  // At setpoint the drive must be exactly zero
  a_zero_at_target: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == '0)
    else $error("at_target result with nonzero drive");

  // An accepted transfer always starts the error check
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> state == ST_CHECK)
    else $error("accepted item did not start processing");

  // A finished item is always loaded into the output register
  a_out_load: assert property (@(posedge clk) disable iff (rst)
    state == ST_OUT && (!m_tvalid || m_tready) |=> m_tvalid && state == ST_IDLE)
    else $error("result not delivered to output register");

  // Multiplier runs exactly DIGIT_COUNT digits
  a_mul_len: assert property (@(posedge clk) disable iff (rst)
    state == ST_MUL && digit_cnt == DIGIT_LAST |=> state == ST_STORE)
    else $error("multiplier digit count overrun");
`endif

endmodule

// File: sim/testbench.sv
// Self-checking bench for pid_filtered_derivative_clamped: stream in/out, register port.
// Needs pidfd_pkg and the core RTL; a built-in predictor tracks the controller state.
`timescale 1ns / 1ps

module testbench;
  import pidfd_pkg::*;

  // Q16.16 coefficients of the fixed T = tau = 0.02 discretization
  localparam int     Q_BITS  = 16;
  localparam longint I_SCALE = 655;       // 0.5*T
  localparam longint D_SCALE = 2184533;   // 2/(2*tau+T)
  localparam longint DECAY_K = 21845;     // (2*tau-T)/(2*tau+T)
  localparam longint VMAX    = 64'sd2147483647;
  localparam longint VMIN    = -VMAX - 1;
  localparam int     PHASES  = 12;
  localparam int     PER_PHASE = 100;

  typedef struct packed {
    word_t drive;
    logic  at_target;
  } drive_result_t;

  // register programs used by the random part
  typedef enum {TUNE_TYPICAL, TUNE_SATURATE, TUNE_INVERTED, TUNE_WILD} tuning_t;

  // Tracks register values and loop state, predicts one result per transfer in.
  class drive_scoreboard;
    longint gain_p, gain_i, gain_d, deadband;
    longint drive_hi, drive_lo, accum_hi, accum_lo;
    longint accum, last_err, deriv, last_meas;
    drive_result_t expected_drives[$];
    int mismatches, samples, at_target_hits, clamped_hits, results_seen;

    function new();
      gain_p = 0;
      gain_i = 0;
      gain_d = 0;
      deadband = 66;
      drive_hi = 45875;
      drive_lo = -45875;
      accum_hi = 32768;
      accum_lo = -32768;
      accum = 0;
      last_err = 0;
      deriv = 0;
      last_meas = 0;
      mismatches = 0;
      samples = 0;
      at_target_hits = 0;
      clamped_hits = 0;
      results_seen = 0;
    endfunction

    static function longint clip(longint v);
      if (v > VMAX) return VMAX;
      if (v < VMIN) return VMIN;
      return v;
    endfunction

    // exact product, floor shift, saturate
    static function longint fmul(longint a, longint b);
      return clip((a * b) >>> Q_BITS);
    endfunction

    // upper limit is tested first, so it wins on inverted limits
    static function longint bound(longint v, longint hi, longint lo);
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
    endfunction

    function void set_register(logic [CFG_INDEX_WIDTH-1:0] index, logic [DATA_WIDTH-1:0] data);
      case (index)
        REG_GAIN_P:      gain_p = longint'(data[30:0]);
        REG_GAIN_I:      gain_i = longint'(data[30:0]);
        REG_GAIN_D:      gain_d = longint'(data[30:0]);
        REG_DEADBAND:    deadband = longint'(data[30:0]);
        REG_DRIVE_UPPER: drive_hi = longint'(signed'(data));
        REG_DRIVE_LOWER: drive_lo = longint'(signed'(data));
        REG_ACCUM_UPPER: accum_hi = longint'(signed'(data));
        REG_ACCUM_LOWER: accum_lo = longint'(signed'(data));
        default: ;
      endcase
    endfunction

    function void note_sample(word_t target, word_t measured);
      longint tgt, meas, err, mag, prop, inc, dterm, decay, raw, total;
      drive_result_t res;
      tgt = longint'(target);
      meas = longint'(measured);
      err = clip(tgt - meas);
      mag = (err < 0) ? -err : err;
      samples++;
      if (mag <= deadband) begin
        // inside tolerance: zero drive, state untouched
        res.drive = '0;
        res.at_target = 1'b1;
        at_target_hits++;
        expected_drives.insert(expected_drives.size(), res);
        return;
      end
      prop = fmul(gain_p, err);
      inc = fmul(gain_i, fmul(clip(err + last_err), I_SCALE));
      accum = bound(clip(accum + inc), accum_hi, accum_lo);
      dterm = fmul(gain_d, fmul(clip(meas - last_meas), D_SCALE));
      decay = fmul(deriv, DECAY_K);
      deriv = clip(-(dterm + decay));
      raw = clip(prop + accum + deriv);
      total = bound(raw, drive_hi, drive_lo);
      if (total != raw) clamped_hits++;
      last_err = err;
      last_meas = meas;
      res.drive = word_t'(total);
      res.at_target = 1'b0;
      expected_drives.insert(expected_drives.size(), res);
    endfunction

    function void check_drive(logic [DATA_WIDTH-1:0] drive, logic at_target);
      drive_result_t want;
      results_seen++;
      if (expected_drives.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d: none expected, got drive %0d at_target %b",
                   results_seen, $signed(drive), at_target);
        return;
      end
      want = expected_drives.pop_front();
      if (drive !== want.drive || at_target !== want.at_target) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d: drive exp %0d got %0d, at_target exp %b got %b",
                   results_seen, want.drive, $signed(drive), want.at_target, at_target);
      end
    endfunction

    function int outstanding();
      return expected_drives.size();
    endfunction
  endclass

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       s_tvalid = 1'b0;
  logic                       s_tready;
  logic [2*DATA_WIDTH-1:0]    s_tdata = '0;      // target[31:0], measured[63:32]
  logic                       m_tvalid;
  logic                       m_tready = 1'b0;
  logic [DATA_WIDTH-1:0]      m_tdata;           // drive[31:0]
  logic                       m_tuser;           // at_target
  logic                       cfg_we = 1'b0;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
  logic [DATA_WIDTH-1:0]      cfg_data = '0;

  drive_scoreboard sb = new();
  bit     calm = 1'b0;        // both sides stop idling while set
  longint set_point = 0;      // held setpoint of the tracking stimulus
  longint plant = 0;          // simulated process value following it
  int     settings_applied = 0;

  pid_filtered_derivative_clamped dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  // receiver: stalls about 35% of cycles unless calm
  always @(posedge clk) begin
    if (rst) m_tready <= 1'b0;
    else m_tready <= calm || ($urandom_range(99) >= 35);
  end

  // result side: sampled values at the edge, so no ordering race with the DUT
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_drive(m_tdata, m_tuser);
  end

  // one register write per cycle; caller drops cfg_we after the last one
  task automatic cfg_write(input logic [CFG_INDEX_WIDTH-1:0] index,
                           input logic [DATA_WIDTH-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_data <= data;
    @(posedge clk);
    sb.set_register(index, data);
  endtask

  // Gains and deadband get a random bit 31, which the block must ignore.
  task automatic program_regs(input longint gp, input longint gi, input longint gd,
                              input longint db, input longint dhi, input longint dlo,
                              input longint ahi, input longint alo);
    cfg_write(REG_GAIN_P, {1'($urandom_range(1)), gp[30:0]});
    cfg_write(REG_GAIN_I, {1'($urandom_range(1)), gi[30:0]});
    cfg_write(REG_GAIN_D, {1'($urandom_range(1)), gd[30:0]});
    cfg_write(REG_DEADBAND, {1'($urandom_range(1)), db[30:0]});
    cfg_write(REG_DRIVE_UPPER, dhi[31:0]);
    cfg_write(REG_DRIVE_LOWER, dlo[31:0]);
    cfg_write(REG_ACCUM_UPPER, ahi[31:0]);
    cfg_write(REG_ACCUM_LOWER, alo[31:0]);
    cfg_we <= 1'b0;
    settings_applied++;
  endtask

  // signed uniform value in [-r, r]
  function automatic longint srand(input longint r);
    return longint'($urandom_range(0, 32'(2 * r))) - r;
  endfunction

  function automatic word_t corner_word();
    case ($urandom_range(5))
      0: return WORD_MIN;
      1: return WORD_MAX;
      2: return '0;
      3: return '1;
      default: return word_t'($urandom);
    endcase
  endfunction

  task automatic program_tuning(input tuning_t kind);
    longint gp, gi, gd, db, dhi, dlo, ahi, alo;
    // typical loop tuning first, overridden per kind
    gp = $urandom_range(0, 4 << 16);
    gi = $urandom_range(0, 4 << 16);
    gd = $urandom_range(0, 1 << 16);
    db = $urandom_range(0, 1000);
    dhi = $urandom_range(1 << 16, 50 << 16);
    dlo = -longint'($urandom_range(1 << 16, 50 << 16));
    ahi = $urandom_range(1 << 14, 20 << 16);
    alo = -longint'($urandom_range(1 << 14, 20 << 16));
    case (kind)
      TUNE_SATURATE: begin
        // every gain at full scale, no tolerance, limits at the word range
        gp = VMAX; gi = VMAX; gd = VMAX; db = 0;
        dhi = VMAX; dlo = VMIN; ahi = VMAX; alo = VMIN;
      end
      TUNE_INVERTED: begin
        dhi = -longint'($urandom_range(1, 2 << 16));
        dlo = $urandom_range(0, 2 << 16);
        ahi = -longint'($urandom_range(1, 2 << 16));
        alo = $urandom_range(0, 2 << 16);
      end
      TUNE_WILD: begin
        gp = $urandom; gi = $urandom; gd = $urandom;
        db = ($urandom_range(3) == 0) ? longint'($urandom) : longint'($urandom_range(0, 5000));
        dhi = longint'(word_t'($urandom)); dlo = longint'(word_t'($urandom));
        ahi = longint'(word_t'($urandom)); alo = longint'(word_t'($urandom));
      end
      default: ;
    endcase
    program_regs(gp, gi, gd, db, dhi, dlo, ahi, alo);
  endtask

  // Mostly a closed-loop-like trace; some near-tolerance, moderate and corner values.
  function automatic void random_sample(output word_t tgt, output word_t meas);
    int unsigned pick;
    longint span;
    pick = $urandom_range(99);
    if (pick < 60) begin
      if ($urandom_range(9) == 0) set_point = srand(20 << 16);
      plant = drive_scoreboard::clip(plant + (set_point - plant) / 4 + srand(1 << 14));
      tgt = word_t'(set_point);
      meas = word_t'(plant);
    end else if (pick < 75) begin
      span = (sb.deadband > (1 << 20)) ? (1 << 20) : sb.deadband;
      tgt = word_t'(set_point);
      meas = word_t'(drive_scoreboard::clip(set_point + srand(span + 3)));
    end else if (pick < 90) begin
      tgt = word_t'(srand(100 << 16));
      meas = word_t'(srand(100 << 16));
    end else begin
      tgt = corner_word();
      meas = corner_word();
    end
  endfunction

  // One input transfer; random idle cycles before it unless calm.
  // tvalid stays high across back-to-back transfers.
  task automatic send(input word_t tgt, input word_t meas);
    while (!calm && $urandom_range(99) < 35) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {meas, tgt};
    do @(posedge clk); while (!(s_tvalid && s_tready));
    sb.note_sample(tgt, meas);
  endtask

  // hold the input off until every predicted result has been taken
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (sb.outstanding() != 0);
  endtask

  initial begin
    word_t tgt, meas;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // moderate gains, wide limits: tolerance edges and error saturation
    program_regs(2 << 16, 3 << 15, 1 << 14, 66, 100 << 16, -(100 << 16),
                 10 << 16, -(10 << 16));
    send(0, 0);
    send(66, 0);
    send(0, 66);
    send(67, 0);
    send(0, 67);
    send(65536, 0);
    send(65536, 16384);
    send(65536, 65536);
    send(WORD_MAX, WORD_MIN);
    send(WORD_MIN, WORD_MAX);
    send(WORD_MIN, 0);
    send(WORD_MAX, WORD_MAX);
    send(WORD_MIN, WORD_MIN);
    send(-1, 0);
    send(32'h5555_5555, 32'hAAAA_AAAA);
    send(32'hAAAA_AAAA, 32'h5555_5555);
    send(0, WORD_MAX);
    drain();

    // full-scale gains and widest tolerance: only the most negative error escapes it
    program_regs(VMAX, VMAX, VMAX, VMAX, VMAX, VMIN, VMAX, VMIN);
    send(WORD_MIN, 0);
    send(0, WORD_MIN);
    send(WORD_MAX, 0);
    send(WORD_MIN, 1);
    drain();

    // inverted output and integrator limits, zero tolerance
    program_regs(1 << 16, 1 << 16, 1 << 16, 0, -(1 << 16), 1 << 16, -(1 << 15), 1 << 15);
    send(1000, 0);
    send(0, 1000);
    send(5 << 16, 0);
    send(7, 7);

    for (int phase = 0; phase < PHASES; phase++) begin
      drain();
      if (phase == 4) program_tuning(TUNE_SATURATE);
      else if (phase == 7) program_tuning(TUNE_INVERTED);
      else if (phase % 3 == 1) program_tuning(TUNE_WILD);
      else program_tuning(TUNE_TYPICAL);
      calm = (phase == 3);
      for (int i = 0; i < PER_PHASE; i++) begin
        if (i == PER_PHASE / 2 && phase % 4 == 2) drain();
        random_sample(tgt, meas);
        send(tgt, meas);
      end
    end
    calm = 1'b0;

    drain();
    // a stray result after the last expected one would show up here
    repeat (60) @(posedge clk);
    if (sb.outstanding() != 0) begin
      $display("%0d expected results never arrived", sb.outstanding());
      sb.mismatches += sb.outstanding();
    end
    $display("stepped the controller %0d times under %0d register settings",
             sb.samples, settings_applied);
    $display("%0d steps inside tolerance, %0d steps limited by the output clamp",
             sb.at_target_hits, sb.clamped_hits);
    if (sb.mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // watchdog, many times the slowest expected run
  initial begin
    #2000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/pidfd_pkg.sv
rtl/core/pid_filtered_derivative_clamped.sv
sim/testbench.sv
